@@ hw/rtl/mcwt_pkg.sv @@
// Shared constants, codes and types of the multi-client watchdog table.
`timescale 1ns / 1ps

package mcwt_pkg;

    // Table geometry.
    localparam int ENTRIES  = 32;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int KEY_W    = (KEY_BITS < 32) ? KEY_BITS : 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_EN   = 1'b1;
    localparam logic [31:0] JUMP_RESET = 32'd864000;

    // Action codes.
    localparam logic [2:0] ACT_REGISTER  = 3'd0;
    localparam logic [2:0] ACT_KEEPALIVE = 3'd1;
    localparam logic [2:0] ACT_DELETE    = 3'd2;
    localparam logic [2:0] ACT_CLEAR     = 3'd3;
    localparam logic [2:0] ACT_CHECK     = 3'd4;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_TRIPPED = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] client_key;
        logic [30:0] timeout_secs;
        logic [31:0] now_secs;
    } t_item;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] slot;
        logic [5:0] active_clients;
        logic       power_off;
    } t_result;

    // One stored table entry.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [31:0]      alive;
        logic [30:0]      timeout;
    } t_entry;

    // Per-entry evaluation flags.
    typedef struct packed {
        logic key_hit;
        logic resync;
        logic trip;
    } t_eval;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

endpackage

@@ hw/rtl/mcwt_entry_ram.sv @@
// Entry memory: one write port, one registered read port.
`timescale 1ns / 1ps

module mcwt_entry_ram
    import mcwt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [ENTRIES];
    t_entry r_rdata;

    // Write and read in the same clocked block; read data arrives in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/mcwt_eval.sv @@
// Evaluation of one entry read back from memory: key match, resync and expiry.
`timescale 1ns / 1ps

module mcwt_eval
    import mcwt_pkg::*;
(
    input  t_entry           i_entry,
    input  logic             i_valid,
    input  logic [KEY_W-1:0] i_key,
    input  logic [31:0]      i_now,
    input  logic [31:0]      i_limit,
    output t_eval            o_eval
);

    logic [32:0] gap;
    logic        gap_neg;
    logic        over_limit;
    logic        over_timeout;

    // Signed gap over 33 bits, so both unsigned times fit without wrapping.
    assign gap          = {1'b0, i_now} - {1'b0, i_entry.alive};
    assign gap_neg      = gap[32];
    assign over_limit   = !gap_neg && (gap[31:0] > i_limit);
    assign over_timeout = !gap_neg && (gap[31:0] > {1'b0, i_entry.timeout});

    // An entry whose gap exceeds the jump limit is resynchronized instead of tripped.
    always_comb begin
        o_eval.key_hit = i_valid && (i_entry.key == i_key);
        o_eval.resync  = i_valid && over_limit;
        o_eval.trip    = i_valid && !over_limit && over_timeout;
    end

endmodule

@@ hw/rtl/multi_client_watchdog_table.sv @@
// Top level of the multi-client watchdog table: control, valid bits and counters.
`timescale 1ns / 1ps

//  Channel   Signals                                  Direction  Handshake
//  item      start, busy, i_item                      in         start && !busy
//  result    o_done, o_result                         out        o_done, one cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata         in         i_cfg_we
//
//  Register, keepalive, delete and enabled checks scan the entry RAM, one read
//  per cycle, and end on the first hit or after the last slot. Clear, unknown
//  actions, disabled checks and checks while tripped answer in the cycle after
//  accept.
//  Reset is synchronous; valid bits clear at once, so no clearing pass is needed.
//  The receiver cannot stall: each result is shown for exactly one cycle.

module multi_client_watchdog_table
    import mcwt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_item                 i_item,
    output logic                  o_done,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_state             r_state, n_state;
    t_item              r_item, n_item;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_ev_pend, n_ev_pend;
    logic [IDX_W-1:0]   r_ev_idx, n_ev_idx;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_tripped, n_tripped;
    logic [IDX_W-1:0]   r_tslot, n_tslot;
    logic               r_free_found, n_free_found;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;
    logic               r_done, n_done;
    t_result            r_out, n_out;
    logic [31:0]        r_jump_limit;
    logic               r_check_en;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_entry             mem_wdata;
    t_entry             mem_rdata;
    t_eval              ev;
    logic               is_reg;
    logic               is_check;
    logic               ev_valid;
    logic               hit;
    logic               last;
    logic               free_now;
    logic [IDX_W-1:0]   free_idx_now;

    mcwt_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    assign ev_valid = r_valid[r_ev_idx];

    mcwt_eval u_eval (
        .i_entry (mem_rdata),
        .i_valid (ev_valid),
        .i_key   (r_item.client_key[KEY_W-1:0]),
        .i_now   (r_item.now_secs),
        .i_limit (r_jump_limit),
        .o_eval  (ev)
    );

    assign is_reg   = (r_item.action == ACT_REGISTER);
    assign is_check = (r_item.action == ACT_CHECK);
    assign hit      = is_check ? ev.trip : ev.key_hit;
    assign last     = (r_ev_idx == IDX_W'(ENTRIES - 1));

    // First free slot seen so far, including the entry under evaluation.
    assign free_now     = r_free_found || !ev_valid;
    assign free_idx_now = r_free_found ? r_free_idx : r_ev_idx;

    // Next-state logic for the scan sequencer.
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_idx        = r_idx;
        n_ev_pend    = 1'b0;
        n_ev_idx     = r_ev_idx;
        n_valid      = r_valid;
        n_count      = r_count;
        n_tripped    = r_tripped;
        n_tslot      = r_tslot;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_done       = 1'b0;
        n_out        = r_out;

        mem_we            = 1'b0;
        mem_waddr         = r_ev_idx;
        mem_wdata.key     = is_reg ? r_item.client_key[KEY_W-1:0] : mem_rdata.key;
        mem_wdata.alive   = r_item.now_secs;
        mem_wdata.timeout = is_reg ? r_item.timeout_secs : mem_rdata.timeout;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item                = i_item;
                    n_idx                 = '0;
                    n_free_found          = 1'b0;
                    n_out.status          = ST_OK;
                    n_out.slot            = '0;
                    n_out.active_clients  = 6'(r_count);
                    n_out.power_off       = r_tripped;
                    case (i_item.action)
                        ACT_REGISTER, ACT_KEEPALIVE, ACT_DELETE: begin
                            n_state = S_SCAN;
                        end
                        ACT_CLEAR: begin
                            n_valid              = '0;
                            n_count              = '0;
                            n_out.active_clients = '0;
                            n_done               = 1'b1;
                        end
                        ACT_CHECK: begin
                            if (!r_check_en) begin
                                n_done = 1'b1;
                            end else if (r_tripped) begin
                                n_out.status = ST_TRIPPED;
                                n_out.slot   = 5'(r_tslot);
                                n_done       = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Issue one read per cycle until every slot has been requested.
                if (r_idx != CNT_W'(ENTRIES)) begin
                    n_ev_pend = 1'b1;
                    n_ev_idx  = r_idx[IDX_W-1:0];
                    n_idx     = CNT_W'(r_idx + 1'b1);
                end
                // Evaluate the entry whose data has just arrived.
                if (r_ev_pend) begin
                    if (!r_free_found && !ev_valid) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_ev_idx;
                    end
                    if (is_check && ev.resync) begin
                        mem_we = 1'b1;
                    end
                    if (hit || last) begin
                        n_state   = S_IDLE;
                        n_ev_pend = 1'b0;
                        n_done    = 1'b1;
                        case (r_item.action)
                            ACT_REGISTER: begin
                                if (hit) begin
                                    n_out.status = ST_DUP;
                                    n_out.slot   = 5'(r_ev_idx);
                                end else if (!free_now) begin
                                    n_out.status = ST_FULL;
                                end else begin
                                    mem_we                = 1'b1;
                                    mem_waddr             = free_idx_now;
                                    n_valid[free_idx_now] = 1'b1;
                                    n_count               = CNT_W'(r_count + 1'b1);
                                    n_out.slot            = 5'(free_idx_now);
                                    n_out.active_clients  = 6'(r_count + 1'b1);
                                end
                            end
                            ACT_KEEPALIVE: begin
                                if (hit) begin
                                    mem_we     = 1'b1;
                                    n_out.slot = 5'(r_ev_idx);
                                end else begin
                                    n_out.status = ST_MISSING;
                                end
                            end
                            ACT_DELETE: begin
                                if (hit) begin
                                    n_valid[r_ev_idx] = 1'b0;
                                    if (r_count != '0) begin
                                        n_count              = CNT_W'(r_count - 1'b1);
                                        n_out.active_clients = 6'(r_count - 1'b1);
                                    end
                                    n_out.slot = 5'(r_ev_idx);
                                end else begin
                                    n_out.status = ST_MISSING;
                                end
                            end
                            ACT_CHECK: begin
                                if (hit) begin
                                    n_tripped       = 1'b1;
                                    n_tslot         = r_ev_idx;
                                    n_out.status    = ST_TRIPPED;
                                    n_out.slot      = 5'(r_ev_idx);
                                    n_out.power_off = 1'b1;
                                end
                            end
                            default: begin
                                n_out.status = ST_OK;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_ev_pend    <= 1'b0;
            r_valid      <= '0;
            r_count      <= '0;
            r_tripped    <= 1'b0;
            r_tslot      <= '0;
            r_free_found <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_ev_pend    <= n_ev_pend;
            r_valid      <= n_valid;
            r_count      <= n_count;
            r_tripped    <= n_tripped;
            r_tslot      <= n_tslot;
            r_free_found <= n_free_found;
            r_done       <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_ev_idx   <= n_ev_idx;
        r_free_idx <= n_free_idx;
        r_out      <= n_out;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_limit <= JUMP_RESET;
            r_check_en   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_JUMP_LIMIT: r_jump_limit <= i_cfg_wdata[31:0];
                CFG_CHECK_EN:   r_check_en   <= i_cfg_wdata[0];
                default:        r_check_en   <= r_check_en;
            endcase
        end
    end

    assign busy     = (r_state == S_SCAN);
    assign o_done   = r_done;
    assign o_result = r_out;

endmodule
